/* sv/ucjk_pkg.sv */
`default_nettype none

package ucjk_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int CP_WIDTH = 21;
    localparam int OUT_COUNT_WIDTH = 16;

    localparam logic [7:0] THRESHOLD_RESET = 8'd6;

    localparam logic [CP_WIDTH-1:0] CJK_EXT_A_LO  = 21'h03400;
    localparam logic [CP_WIDTH-1:0] CJK_EXT_A_HI  = 21'h04dbf;
    localparam logic [CP_WIDTH-1:0] CJK_UNIFIED_LO = 21'h04e00;
    localparam logic [CP_WIDTH-1:0] CJK_UNIFIED_HI = 21'h09fff;
    localparam logic [CP_WIDTH-1:0] CJK_COMPAT_LO = 21'h0f900;
    localparam logic [CP_WIDTH-1:0] CJK_COMPAT_HI = 21'h0faff;

    localparam logic [CP_WIDTH-1:0] IDEO_COMMA     = 21'h03001;
    localparam logic [CP_WIDTH-1:0] IDEO_STOP      = 21'h03002;
    localparam logic [CP_WIDTH-1:0] FW_EXCLAMATION = 21'h0ff01;
    localparam logic [CP_WIDTH-1:0] FW_COLON       = 21'h0ff1a;
    localparam logic [CP_WIDTH-1:0] FW_SEMICOLON   = 21'h0ff1b;
    localparam logic [CP_WIDTH-1:0] FW_QUESTION    = 21'h0ff1f;

    localparam logic [7:0] ASCII_PERIOD   = 8'h2e;
    localparam logic [7:0] ASCII_COMMA    = 8'h2c;
    localparam logic [7:0] ASCII_EXCLAIM  = 8'h21;
    localparam logic [7:0] ASCII_QUESTION = 8'h3f;
    localparam logic [7:0] ASCII_COLON    = 8'h3a;
    localparam logic [7:0] ASCII_SEMI     = 8'h3b;
    localparam logic [7:0] ASCII_NEWLINE  = 8'h0a;

    localparam logic [1:0] CONT_TAG = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic                       has_cjk;
        logic [OUT_COUNT_WIDTH-1:0] ideograph_count;
        logic                       punctuation_seen;
        logic                       sentence_like;
    } out_t;

    function automatic logic is_ideograph(input logic [CP_WIDTH-1:0] cp);
        return (cp >= CJK_EXT_A_LO && cp <= CJK_EXT_A_HI) ||
               (cp >= CJK_UNIFIED_LO && cp <= CJK_UNIFIED_HI) ||
               (cp >= CJK_COMPAT_LO && cp <= CJK_COMPAT_HI);
    endfunction

    function automatic logic is_wide_punct(input logic [CP_WIDTH-1:0] cp);
        return cp == IDEO_COMMA || cp == IDEO_STOP || cp == FW_EXCLAMATION ||
               cp == FW_COLON || cp == FW_SEMICOLON || cp == FW_QUESTION;
    endfunction

    function automatic logic is_ascii_punct(input logic [7:0] b);
        return b == ASCII_PERIOD || b == ASCII_COMMA || b == ASCII_EXCLAIM ||
               b == ASCII_QUESTION || b == ASCII_COLON || b == ASCII_SEMI ||
               b == ASCII_NEWLINE;
    endfunction

endpackage

`default_nettype wire

/* sv/utf8_cjk_sentence_classifier.sv */
// an accepted last byte passes the input register, then its result goes to the output register
// throughput: one byte per cycle unless stalled; the input register and the state update sit in one stage
// the only stall source is a held result register under out_stall
// reset: rst_n clears the decoder state, the count, the punctuation flag and both valids
// the threshold register resets to 6 and keeps its value across texts
`default_nettype none

module utf8_cjk_sentence_classifier #(
    parameter int COUNT_WIDTH = ucjk_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire ucjk_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output ucjk_pkg::out_t      out_data,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [7:0]     cfg_data
);

    localparam int CPW = ucjk_pkg::CP_WIDTH;
    localparam int OCW = ucjk_pkg::OUT_COUNT_WIDTH;
    localparam int CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [7:0]             threshold_reg;
    logic                   in_valid_reg;
    ucjk_pkg::in_t          in_data_reg;
    logic [CPW-1:0]         partial_reg;
    logic [CPW-1:0]         partial_next;
    logic [1:0]             expected_reg;
    logic [1:0]             expected_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   punct_reg;
    logic                   punct_next;
    logic                   out_valid_reg;
    ucjk_pkg::out_t         out_data_reg;
    ucjk_pkg::out_t         out_data_next;

    logic                   advance;
    logic [7:0]             b;
    logic                   cont;
    logic [CPW-1:0]         cp_joined;
    logic                   cp_done;
    logic [CPW-1:0]         cp_done_val;
    logic [OCW-1:0]         shown_count;

    assign advance   = !(out_valid_reg && out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign b         = in_data_reg.text_byte;
    assign cont      = (b[7:6] == ucjk_pkg::CONT_TAG);
    assign cp_joined = {partial_reg[CPW-7:0], b[5:0]};

    generate
        if (COUNT_WIDTH > OCW) begin : g_clamp
            assign shown_count = (|count_next[COUNT_WIDTH-1:OCW]) ? {OCW{1'b1}}
                                                                 : count_next[OCW-1:0];
        end else begin : g_extend
            assign shown_count = OCW'(count_next);
        end
    endgenerate

    always_comb
    begin
        partial_next  = partial_reg;
        expected_next = expected_reg;
        count_next    = count_reg;
        punct_next    = punct_reg;
        cp_done       = 1'b0;
        cp_done_val   = cp_joined;

        if (expected_reg != 2'd0 && cont)
        begin
            partial_next  = cp_joined;
            expected_next = expected_reg - 2'd1;
            cp_done       = (expected_reg == 2'd1);
        end
        else
        begin
            partial_next  = '0;
            expected_next = 2'd0;
            if (b[7] == 1'b0)
            begin
                if (ucjk_pkg::is_ascii_punct(b))
                begin
                    punct_next = 1'b1;
                end
            end
            else if (b[7:5] == ucjk_pkg::LEAD2_TAG)
            begin
                partial_next  = CPW'(b[4:0]);
                expected_next = 2'd1;
            end
            else if (b[7:4] == ucjk_pkg::LEAD3_TAG)
            begin
                partial_next  = CPW'(b[3:0]);
                expected_next = 2'd2;
            end
            else if (b[7:3] == ucjk_pkg::LEAD4_TAG)
            begin
                partial_next  = CPW'(b[2:0]);
                expected_next = 2'd3;
            end
        end

        if (cp_done)
        begin
            if (ucjk_pkg::is_ideograph(cp_done_val) && count_reg != COUNT_MAX)
            begin
                count_next = count_reg + COUNT_WIDTH'(1);
            end
            if (ucjk_pkg::is_wide_punct(cp_done_val))
            begin
                punct_next = 1'b1;
            end
        end

        out_data_next.has_cjk          = (count_next != '0);
        out_data_next.ideograph_count  = shown_count;
        out_data_next.punctuation_seen = punct_next;
        out_data_next.sentence_like    = (CMP_W'(count_next) >= CMP_W'(threshold_reg)) ||
                                         punct_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= ucjk_pkg::THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_data_reg <= in_data;
        end
    end

    // decoder state, cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg  <= '0;
            expected_reg <= 2'd0;
            count_reg    <= '0;
            punct_reg    <= 1'b0;
        end
        else if (in_valid_reg && advance)
        begin
            if (in_data_reg.end_of_text)
            begin
                partial_reg  <= '0;
                expected_reg <= 2'd0;
                count_reg    <= '0;
                punct_reg    <= 1'b0;
            end
            else
            begin
                partial_reg  <= partial_next;
                expected_reg <= expected_next;
                count_reg    <= count_next;
                punct_reg    <= punct_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && in_data_reg.end_of_text;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && in_data_reg.end_of_text)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

/* sim/tb_utf8_cjk_sentence_classifier.sv */
`timescale 1ns / 1ps

module tb_utf8_cjk_sentence_classifier;

    localparam int STALL_LIMIT = 2000;
    localparam longint unsigned COUNT_MAX = (64'd1 << ucjk_pkg::COUNT_WIDTH_DEFAULT) - 1;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    ucjk_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_stall;
    ucjk_pkg::out_t out_data;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [7:0]     cfg_data;

    int         send_idle_pct;
    int         recv_stall_pct;
    int         idle_cycles;
    int         bytes_sent;
    int         texts_sent;
    int         results_seen;
    logic [7:0] mid_threshold;
    logic [7:0] text_q[$];

    class cjk_scoreboard;
        logic [7:0]      threshold;
        logic [20:0]     partial_cp;
        logic [1:0]      cont_left;
        longint unsigned ideo_count;
        bit              punct_seen;
        ucjk_pkg::out_t  pending_summaries[$];
        int              errors;

        function new();
            threshold = ucjk_pkg::THRESHOLD_RESET;
            errors = 0;
            clear_text();
        endfunction

        function void clear_text();
            partial_cp = '0;
            cont_left = '0;
            ideo_count = 0;
            punct_seen = 1'b0;
        endfunction

        function void count_code_point(logic [20:0] cp);
            if (((cp >= ucjk_pkg::CJK_EXT_A_LO && cp <= ucjk_pkg::CJK_EXT_A_HI) ||
                 (cp >= ucjk_pkg::CJK_UNIFIED_LO && cp <= ucjk_pkg::CJK_UNIFIED_HI) ||
                 (cp >= ucjk_pkg::CJK_COMPAT_LO && cp <= ucjk_pkg::CJK_COMPAT_HI)) &&
                ideo_count < COUNT_MAX)
                ideo_count++;
            if (cp == ucjk_pkg::IDEO_COMMA || cp == ucjk_pkg::IDEO_STOP ||
                cp == ucjk_pkg::FW_EXCLAMATION || cp == ucjk_pkg::FW_COLON ||
                cp == ucjk_pkg::FW_SEMICOLON || cp == ucjk_pkg::FW_QUESTION)
                punct_seen = 1'b1;
        endfunction

        function void note_request(ucjk_pkg::in_t req);
            logic [7:0]     b;
            bit             taken;
            ucjk_pkg::out_t summary;
            b = req.text_byte;
            taken = 1'b0;
            if (cont_left != 0)
            begin
                if (b[7:6] == ucjk_pkg::CONT_TAG)
                begin
                    partial_cp = {partial_cp[14:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 0)
                        count_code_point(partial_cp);
                    taken = 1'b1;
                end
                else
                begin
                    // broken sequence: the byte starts over as a lead byte
                    cont_left = '0;
                    partial_cp = '0;
                end
            end
            if (!taken)
            begin
                if (!b[7])
                begin
                    if (b == ucjk_pkg::ASCII_PERIOD || b == ucjk_pkg::ASCII_COMMA ||
                        b == ucjk_pkg::ASCII_EXCLAIM || b == ucjk_pkg::ASCII_QUESTION ||
                        b == ucjk_pkg::ASCII_COLON || b == ucjk_pkg::ASCII_SEMI ||
                        b == ucjk_pkg::ASCII_NEWLINE)
                        punct_seen = 1'b1;
                end
                else if (b[7:5] == ucjk_pkg::LEAD2_TAG)
                begin
                    partial_cp = {16'd0, b[4:0]};
                    cont_left = 2'd1;
                end
                else if (b[7:4] == ucjk_pkg::LEAD3_TAG)
                begin
                    partial_cp = {17'd0, b[3:0]};
                    cont_left = 2'd2;
                end
                else if (b[7:3] == ucjk_pkg::LEAD4_TAG)
                begin
                    partial_cp = {18'd0, b[2:0]};
                    cont_left = 2'd3;
                end
            end
            if (req.end_of_text)
            begin
                summary.has_cjk = (ideo_count != 0);
                summary.ideograph_count = (ideo_count > 64'hffff) ? 16'hffff : ideo_count[15:0];
                summary.punctuation_seen = punct_seen;
                summary.sentence_like = (ideo_count >= threshold) || punct_seen;
                pending_summaries.insert(pending_summaries.size(), summary);
                clear_text();
            end
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            if (errors < 40)
                $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        task check_result(ucjk_pkg::out_t got);
            ucjk_pkg::out_t want;
            if (pending_summaries.size() == 0)
                report("unrequested result, ideograph_count", got.ideograph_count, 0);
            else
            begin
                want = pending_summaries[0];
                pending_summaries.delete(0);
                if (got.has_cjk !== want.has_cjk)
                    report("has_cjk", got.has_cjk, want.has_cjk);
                if (got.ideograph_count !== want.ideograph_count)
                    report("ideograph_count", got.ideograph_count, want.ideograph_count);
                if (got.punctuation_seen !== want.punctuation_seen)
                    report("punctuation_seen", got.punctuation_seen, want.punctuation_seen);
                if (got.sentence_like !== want.sentence_like)
                    report("sentence_like", got.sentence_like, want.sentence_like);
            end
        endtask
    endclass

    cjk_scoreboard sb = new();

    utf8_cjk_sentence_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(in_data);
            if (out_valid && !out_stall)
            begin
                sb.check_result(out_data);
                results_seen++;
            end
            if (cfg_valid && cfg_ready)
                sb.threshold = cfg_data;
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("utf8_cjk_sentence_classifier: mismatch");
                $finish;
            end
        end
    end

    function automatic void add_byte(input logic [7:0] v);
        text_q.insert(text_q.size(), v);
    endfunction

    function automatic void put_cp(input logic [20:0] cp, input int len);
        case (len)
            1: add_byte({1'b0, cp[6:0]});
            2:
            begin
                add_byte({ucjk_pkg::LEAD2_TAG, cp[10:6]});
                add_byte({ucjk_pkg::CONT_TAG, cp[5:0]});
            end
            3:
            begin
                add_byte({ucjk_pkg::LEAD3_TAG, cp[15:12]});
                add_byte({ucjk_pkg::CONT_TAG, cp[11:6]});
                add_byte({ucjk_pkg::CONT_TAG, cp[5:0]});
            end
            default:
            begin
                add_byte({ucjk_pkg::LEAD4_TAG, cp[20:18]});
                add_byte({ucjk_pkg::CONT_TAG, cp[17:12]});
                add_byte({ucjk_pkg::CONT_TAG, cp[11:6]});
                add_byte({ucjk_pkg::CONT_TAG, cp[5:0]});
            end
        endcase
    endfunction

    function automatic logic [20:0] pick_ideograph();
        logic [20:0] lo;
        logic [20:0] hi;
        case ($urandom_range(2))
            0:
            begin
                lo = ucjk_pkg::CJK_EXT_A_LO;
                hi = ucjk_pkg::CJK_EXT_A_HI;
            end
            1:
            begin
                lo = ucjk_pkg::CJK_UNIFIED_LO;
                hi = ucjk_pkg::CJK_UNIFIED_HI;
            end
            default:
            begin
                lo = ucjk_pkg::CJK_COMPAT_LO;
                hi = ucjk_pkg::CJK_COMPAT_HI;
            end
        endcase
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            default: return lo + 21'($urandom_range(hi - lo));
        endcase
    endfunction

    function automatic logic [20:0] pick_wide_punct();
        case ($urandom_range(5))
            0: return ucjk_pkg::IDEO_COMMA;
            1: return ucjk_pkg::IDEO_STOP;
            2: return ucjk_pkg::FW_EXCLAMATION;
            3: return ucjk_pkg::FW_COLON;
            4: return ucjk_pkg::FW_SEMICOLON;
            default: return ucjk_pkg::FW_QUESTION;
        endcase
    endfunction

    // code points just outside the counted ranges and next to wide punctuation
    function automatic logic [20:0] pick_near_miss();
        case ($urandom_range(9))
            0: return ucjk_pkg::CJK_EXT_A_LO - 21'd1;
            1: return ucjk_pkg::CJK_EXT_A_HI + 21'd1;
            2: return ucjk_pkg::CJK_UNIFIED_LO - 21'd1;
            3: return ucjk_pkg::CJK_UNIFIED_HI + 21'd1;
            4: return ucjk_pkg::CJK_COMPAT_LO - 21'd1;
            5: return ucjk_pkg::CJK_COMPAT_HI + 21'd1;
            6: return ucjk_pkg::IDEO_COMMA - 21'd1;
            7: return ucjk_pkg::IDEO_STOP + 21'd1;
            8: return ucjk_pkg::FW_EXCLAMATION - 21'd1;
            default: return ucjk_pkg::FW_QUESTION + 21'd1;
        endcase
    endfunction

    function automatic logic [20:0] pick_ascii_punct();
        case ($urandom_range(6))
            0: return {13'd0, ucjk_pkg::ASCII_PERIOD};
            1: return {13'd0, ucjk_pkg::ASCII_COMMA};
            2: return {13'd0, ucjk_pkg::ASCII_EXCLAIM};
            3: return {13'd0, ucjk_pkg::ASCII_QUESTION};
            4: return {13'd0, ucjk_pkg::ASCII_COLON};
            5: return {13'd0, ucjk_pkg::ASCII_SEMI};
            default: return {13'd0, ucjk_pkg::ASCII_NEWLINE};
        endcase
    endfunction

    function automatic void put_clean_text(input int n);
        repeat (n)
        begin
            case ($urandom_range(9))
                0, 1, 2: put_cp(pick_ideograph(), 3);
                3: put_cp(pick_wide_punct(), 3);
                4: put_cp(pick_near_miss(), 3);
                5: put_cp(21'($urandom_range(127)), 1);
                6: put_cp(pick_ascii_punct(), 1);
                7: put_cp(21'($urandom_range(21'h7ff, 21'h80)), 2);
                8: put_cp(21'($urandom_range(21'hffff, 21'h800)), 3);
                default:
                begin
                    // overlong four byte form of an ideograph half of the time
                    if ($urandom_range(1) != 0)
                        put_cp(21'($urandom_range(21'h1fffff, 21'h10000)), 4);
                    else
                        put_cp(pick_ideograph(), 4);
                end
            endcase
        end
    endfunction

    function automatic void make_random_text();
        int kind;
        int pos;
        text_q.delete();
        kind = $urandom_range(9);
        if (kind == 0)
        begin
            repeat ($urandom_range(8, 1))
                add_byte(8'($urandom_range(255)));
        end
        else
        begin
            put_clean_text($urandom_range(10, 1));
            if (kind == 1)
            begin
                repeat ($urandom_range(2, 1))
                begin
                    pos = $urandom_range(text_q.size() - 1);
                    case ($urandom_range(3))
                        0: text_q[pos] = 8'($urandom_range(255));
                        1: if (text_q.size() > 1) text_q.delete(pos);
                        2: text_q.insert(pos, 8'($urandom_range(255)));
                        default: if (text_q.size() > 1) text_q.delete(text_q.size() - 1);
                    endcase
                end
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= {b, last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
        bytes_sent += text_q.size();
        texts_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_summaries.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic start_phase(input int send_pct, input int recv_pct, input logic [7:0] value);
        wait_drained();
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        write_threshold(value);
    endtask

    task automatic run_random(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes)
        begin
            make_random_text();
            sent += text_q.size();
            send_text();
            // now and then the sender holds off until every result is back
            if ($urandom_range(14) == 0)
                wait_drained();
        end
    endtask

    task automatic run_directed();
        text_q = '{8'h00};
        send_text();
        text_q = '{8'hff};
        send_text();
        text_q = '{8'h7f};
        send_text();
        text_q = '{ucjk_pkg::ASCII_PERIOD};
        send_text();
        text_q = '{ucjk_pkg::ASCII_NEWLINE};
        send_text();
        text_q = '{8'he4, 8'hb8, 8'h80};
        send_text();
        text_q = '{8'he3, 8'h80, 8'h82};
        send_text();
        // broken sequence, the period is taken as a fresh byte
        text_q = '{8'he4, 8'hb8, ucjk_pkg::ASCII_PERIOD};
        send_text();
        text_q = '{8'h80};
        send_text();
        // cut off at the end of text
        text_q = '{8'he4, 8'hb8};
        send_text();
        text_q = '{8'hf0, 8'h9f, 8'h98, 8'h80};
        send_text();
        text_q = '{8'hc3, 8'ha9};
        send_text();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        bytes_sent = 0;
        texts_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        start_phase(0, 0, 8'd0);
        run_random(160);
        start_phase(54, 0, 8'd255);
        run_random(160);
        start_phase(0, 54, 8'd1);
        run_random(160);
        mid_threshold = 8'($urandom_range(12, 2));
        start_phase(37, 37, mid_threshold);
        run_random(170);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("sent %0d bytes in %0d texts under thresholds 6, 0, 255, 1 and %0d",
                 bytes_sent, texts_sent, mid_threshold);
        $display("checked %0d summaries with idle senders and stalling receivers",
                 results_seen);
        if (sb.errors == 0)
            $display("utf8_cjk_sentence_classifier: match");
        else
            $display("utf8_cjk_sentence_classifier: mismatch");
        $finish;
    end

endmodule
